// File: rtl/core/roc_auc_trapezoid_assert.svh
// Assertion macros used by the ROC area controller.
`ifndef ROC_AUC_TRAPEZOID_ASSERT_SVH
`define ROC_AUC_TRAPEZOID_ASSERT_SVH
// Same-cycle implication under the active-low reset.
`define ROC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication under the active-low reset.
`define ROC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/core/roc_auc_pkg.sv
// ----------------------------------------------------------------------------
// roc_auc_pkg
// Types shared by the ROC area controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none
package roc_auc_pkg;

  localparam int unsigned ScoreW = 32;
  localparam int unsigned AucW   = 17;
  localparam int unsigned CountW = 11;
  localparam int unsigned QuotW  = 17;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic                     label;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [AucW-1:0]   auc;
    logic              degenerate;
    logic [CountW-1:0] positives;
    logic [CountW-1:0] negatives;
  } out_item_t;

  // Controller states, one-hot.
  typedef enum logic [10:0] {
    ST_LOAD       = 11'b000_0000_0001,
    ST_SETUP      = 11'b000_0000_0010,
    ST_PASS_CHK   = 11'b000_0000_0100,
    ST_MERGE_INIT = 11'b000_0000_1000,
    ST_MERGE      = 11'b000_0001_0000,
    ST_SCAN_INIT  = 11'b000_0010_0000,
    ST_SCAN       = 11'b000_0100_0000,
    ST_FINAL      = 11'b000_1000_0000,
    ST_DENOM      = 11'b001_0000_0000,
    ST_DIV        = 11'b010_0000_0000,
    ST_OUT        = 11'b100_0000_0000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sort_init;
    logic merge_init;
    logic merge_step;
    logic scan_init;
    logic scan_step;
    logic final_strip;
    logic denom;
    logic div_step;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic merge_last;
    logic pass_last;
    logic sort_done;
    logic scan_last;
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/roc_auc_ram.sv
// ----------------------------------------------------------------------------
// roc_auc_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module roc_auc_ram #(
  parameter int unsigned Width = 33,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write, and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

// File: rtl/core/roc_auc_ctrl.sv
// ----------------------------------------------------------------------------
// roc_auc_ctrl
// Sequencer: load, merge sort passes, scan, divide and result transfer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "roc_auc_trapezoid_assert.svh"
module roc_auc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_last_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire roc_auc_pkg::status_t status_i,
  output roc_auc_pkg::cmd_t         cmd_o
);

  roc_auc_pkg::state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      roc_auc_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = roc_auc_pkg::ST_SETUP;
        end
      end
      roc_auc_pkg::ST_SETUP: begin
        cmd_o.sort_init = 1'b1;
        state_d         = roc_auc_pkg::ST_PASS_CHK;
      end
      roc_auc_pkg::ST_PASS_CHK: begin
        if (status_i.sort_done) begin
          state_d = roc_auc_pkg::ST_SCAN_INIT;
        end else begin
          state_d = roc_auc_pkg::ST_MERGE_INIT;
        end
      end
      roc_auc_pkg::ST_MERGE_INIT: begin
        cmd_o.merge_init = 1'b1;
        state_d          = roc_auc_pkg::ST_MERGE;
      end
      roc_auc_pkg::ST_MERGE: begin
        cmd_o.merge_step = 1'b1;
        if (status_i.merge_last) begin
          state_d = status_i.pass_last ? roc_auc_pkg::ST_PASS_CHK
                                       : roc_auc_pkg::ST_MERGE_INIT;
        end
      end
      roc_auc_pkg::ST_SCAN_INIT: begin
        cmd_o.scan_init = 1'b1;
        state_d         = roc_auc_pkg::ST_SCAN;
      end
      roc_auc_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = roc_auc_pkg::ST_FINAL;
        end
      end
      roc_auc_pkg::ST_FINAL: begin
        cmd_o.final_strip = 1'b1;
        state_d           = roc_auc_pkg::ST_DENOM;
      end
      roc_auc_pkg::ST_DENOM: begin
        cmd_o.denom = 1'b1;
        state_d     = roc_auc_pkg::ST_DIV;
      end
      roc_auc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = roc_auc_pkg::ST_OUT;
        end
      end
      roc_auc_pkg::ST_OUT: begin
        // The result register takes the result once it is free or being freed.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d     = roc_auc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = roc_auc_pkg::ST_LOAD;
      end
    endcase
    // The result stays offered until its transfer.
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.clear) begin
      out_valid_d = 1'b1;
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= roc_auc_pkg::ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ROC_ASSERT_IMP(a_ready_in_load, clk_i, rst_ni, in_ready_o,
                  state_q == roc_auc_pkg::ST_LOAD, "input ready outside loading")
  `ROC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o,
                  "result withdrawn before its transfer")
  `ROC_ASSERT_NXT(a_clear_offers, clk_i, rst_ni, cmd_o.clear, out_valid_o,
                  "no result offered after the result register was loaded")
  `ROC_ASSERT_NXT(a_div_to_out, clk_i, rst_ni,
                  (state_q == roc_auc_pkg::ST_DIV) && status_i.div_last,
                  state_q == roc_auc_pkg::ST_OUT, "no hand-over after the last divide step")

endmodule
`default_nettype wire

// File: rtl/core/roc_auc_dp.sv
// ----------------------------------------------------------------------------
// roc_auc_dp
// Datapath: item stores, merge pointers, scan accumulators and divider.
// ----------------------------------------------------------------------------
`default_nettype none
module roc_auc_dp #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire roc_auc_pkg::in_item_t in_item_i,
  input  wire roc_auc_pkg::cmd_t     cmd_i,
  output roc_auc_pkg::status_t       status_o,
  output roc_auc_pkg::out_item_t     out_item_o
);

  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW  = $clog2(MAX_ITEMS);
  localparam int unsigned EW  = roc_auc_pkg::ScoreW + 1;
  localparam int unsigned ARW = 2 * CW + 1;
  localparam int unsigned DW  = 2 * CW + 1;
  localparam int unsigned RW  = DW + 1;
  localparam int unsigned QW  = roc_auc_pkg::QuotW;
  localparam int unsigned OW  = roc_auc_pkg::CountW;
  localparam int unsigned KW  = $clog2(QW);

  // Load and sort state.
  logic [CW-1:0] count_q;
  logic [CW:0]   width_q;
  logic [CW-1:0] base_q, lptr_q, lend_q, rptr_q, rend_q, optr_q;
  logic          sel_q;
  // Scan state.
  logic [CW-1:0]                   scan_q, tp_q, fp_q, tpp_q, fpp_q;
  logic [ARW-1:0]                  area_q;
  logic signed [roc_auc_pkg::ScoreW-1:0] last_score_q;
  logic                            first_q;
  // Divider state.
  logic [DW-1:0] den_q;
  logic [RW-1:0] rem_q;
  logic [QW-1:0] quot_q;
  logic [KW-1:0] div_cnt_q;
  // Result register.
  roc_auc_pkg::out_item_t out_d, out_q;

  // Memory ports.
  logic          we_a, we_b;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [EW-1:0] wdata, a_rd_a, a_rd_b, b_rd_a, b_rd_b, src_a, src_b;

  roc_auc_ram #(.Width(EW), .Depth(MAX_ITEMS)) u_ram_a (
    .clk_i     (clk_i),
    .we_i      (we_a),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (a_rd_a),
    .rdata_b_o (a_rd_b)
  );

  roc_auc_ram #(.Width(EW), .Depth(MAX_ITEMS)) u_ram_b (
    .clk_i     (clk_i),
    .we_i      (we_b),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (b_rd_a),
    .rdata_b_o (b_rd_b)
  );

  assign src_a = sel_q ? b_rd_a : a_rd_a;
  assign src_b = sel_q ? b_rd_b : a_rd_b;

  // Run bounds of the next merge, clipped to the item count.
  logic [CW+1:0] sum_w, sum_2w, n_ext;
  logic [CW-1:0] lend_init, rend_init;
  assign n_ext     = {2'b0, count_q};
  assign sum_w     = {2'b0, base_q} + {1'b0, width_q};
  assign sum_2w    = {2'b0, base_q} + {width_q, 1'b0};
  assign lend_init = (sum_w < n_ext) ? sum_w[CW-1:0] : count_q;
  assign rend_init = (sum_2w < n_ext) ? sum_2w[CW-1:0] : count_q;

  // Merge decision: take the left head when the right run is spent or on a
  // higher or equal score.
  logic          take_left;
  logic [CW-1:0] lptr_d, rptr_d, scan_d;
  assign take_left = (lptr_q < lend_q) &&
                     ((rptr_q >= rend_q) ||
                      ($signed(src_a[roc_auc_pkg::ScoreW-1:0]) >=
                       $signed(src_b[roc_auc_pkg::ScoreW-1:0])));
  assign lptr_d = lptr_q + CW'(take_left);
  assign rptr_d = rptr_q + CW'(!take_left);
  assign scan_d = scan_q + CW'(1);

  logic store_ok;
  assign store_ok = count_q < CW'(MAX_ITEMS);

  // Memory port steering.
  always_comb begin
    we_a    = cmd_i.load && store_ok;
    we_b    = 1'b0;
    waddr   = count_q[AW-1:0];
    wdata   = {in_item_i.label, in_item_i.score};
    raddr_a = lptr_d[AW-1:0];
    raddr_b = rptr_d[AW-1:0];
    if (cmd_i.merge_step) begin
      we_a  = sel_q;
      we_b  = !sel_q;
      waddr = optr_q[AW-1:0];
      wdata = take_left ? src_a : src_b;
    end
    if (cmd_i.merge_init) begin
      raddr_a = base_q[AW-1:0];
      raddr_b = lend_init[AW-1:0];
    end
    if (cmd_i.scan_init) begin
      raddr_a = '0;
    end
    if (cmd_i.scan_step) begin
      raddr_a = scan_d[AW-1:0];
    end
  end

  // Trapezoid strip for the group that has just closed.
  logic [ARW-1:0] strip;
  logic [CW:0]    tp_sum;
  logic [CW-1:0]  fp_step;
  logic           boundary, lab;
  logic signed [roc_auc_pkg::ScoreW-1:0] score_rd;
  assign tp_sum   = {1'b0, tp_q} + {1'b0, tpp_q};
  assign fp_step  = fp_q - fpp_q;
  assign strip    = ARW'(fp_step) * ARW'(tp_sum);
  assign score_rd = src_a[roc_auc_pkg::ScoreW-1:0];
  assign lab      = src_a[roc_auc_pkg::ScoreW];
  assign boundary = first_q || (score_rd != last_score_q);

  // Restoring divider step: the first step yields the integer bit.
  logic [RW-1:0] trial;
  logic          fits;
  assign trial = (div_cnt_q == '0) ? rem_q : {rem_q[RW-2:0], 1'b0};
  assign fits  = trial >= {1'b0, den_q};

  // Status to the controller.
  logic merge_last;
  assign merge_last          = (optr_q + CW'(1)) == rend_q;
  assign status_o.merge_last = merge_last;
  assign status_o.pass_last  = sum_2w >= n_ext;
  assign status_o.sort_done  = width_q >= {1'b0, count_q};
  assign status_o.scan_last  = scan_d == count_q;
  assign status_o.div_last   = div_cnt_q == KW'(QW - 1);

  // Control registers of loading, sorting, scanning and dividing, and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      width_q      <= '0;
      base_q       <= '0;
      sel_q        <= 1'b0;
      tp_q         <= '0;
      fp_q         <= '0;
      tpp_q        <= '0;
      fpp_q        <= '0;
      area_q       <= '0;
      last_score_q <= '0;
      first_q      <= 1'b1;
      div_cnt_q    <= '0;
      out_q        <= '0;
    end else begin
      if (cmd_i.load && store_ok) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.sort_init) begin
        width_q <= (CW + 1)'(1);
        base_q  <= '0;
        sel_q   <= 1'b0;
      end
      if (cmd_i.merge_step && merge_last) begin
        if (status_o.pass_last) begin
          base_q  <= '0;
          width_q <= {width_q[CW-1:0], 1'b0};
          sel_q   <= !sel_q;
        end else begin
          base_q <= sum_2w[CW-1:0];
        end
      end
      if (cmd_i.scan_step) begin
        if (boundary) begin
          area_q       <= area_q + strip;
          last_score_q <= score_rd;
          first_q      <= 1'b0;
          tpp_q        <= tp_q;
          fpp_q        <= fp_q;
        end
        if (lab) begin
          tp_q <= tp_q + CW'(1);
        end else begin
          fp_q <= fp_q + CW'(1);
        end
      end
      if (cmd_i.final_strip) begin
        area_q <= area_q + strip;
      end
      if (cmd_i.denom) begin
        div_cnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + KW'(1);
      end
      // The result register is loaded as the data set state is cleared.
      if (cmd_i.clear) begin
        out_q        <= out_d;
        count_q      <= '0;
        tp_q         <= '0;
        fp_q         <= '0;
        tpp_q        <= '0;
        fpp_q        <= '0;
        area_q       <= '0;
        last_score_q <= '0;
        first_q      <= 1'b1;
      end
    end
  end

  // Payload registers: merge pointers, scan index and divider.
  always_ff @(posedge clk_i) begin
    if (cmd_i.merge_init) begin
      lptr_q <= base_q;
      lend_q <= lend_init;
      rptr_q <= lend_init;
      rend_q <= rend_init;
      optr_q <= base_q;
    end
    if (cmd_i.merge_step) begin
      lptr_q <= lptr_d;
      rptr_q <= rptr_d;
      optr_q <= optr_q + CW'(1);
    end
    if (cmd_i.scan_init) begin
      scan_q <= '0;
    end
    if (cmd_i.scan_step) begin
      scan_q <= scan_d;
    end
    if (cmd_i.denom) begin
      den_q  <= (DW'(tp_q) * DW'(fp_q)) << 1;
      rem_q  <= RW'(area_q);
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= fits ? (trial - {1'b0, den_q}) : trial;
      quot_q <= {quot_q[QW-2:0], fits};
    end
  end

  // Result fields.
  logic          degenerate;
  logic [CW+OW-1:0] pos_ext, neg_ext;
  assign degenerate       = (tp_q == '0) || (fp_q == '0);
  assign pos_ext          = {{OW{1'b0}}, tp_q};
  assign neg_ext          = {{OW{1'b0}}, fp_q};
  assign out_d.auc        = degenerate ? '0 : quot_q;
  assign out_d.degenerate = degenerate;
  assign out_d.positives  = pos_ext[OW-1:0];
  assign out_d.negatives  = neg_ext[OW-1:0];
  assign out_item_o       = out_q;

endmodule
`default_nettype wire

// File: rtl/core/roc_auc_trapezoid.sv
// ----------------------------------------------------------------------------
// roc_auc_trapezoid
// Area under the ROC curve of a loaded data set, by the trapezoidal rule.
// ----------------------------------------------------------------------------
// Items are taken one per cycle into a RAM while the block is loading,
// until the item marked last arrives; items beyond MAX_ITEMS are dropped.
// The block then sorts by score with a bottom-up merge sort between two
// ping-pong RAMs in ceil(log2 n) passes, with a set-up step before each
// merged run pair and a check step before each pass and after the last,
// scans the sorted items, adds the last strip, forms the denominator and
// runs a restoring divider. The result then moves into an output register
// once that register is free or being freed, and loading of the next data
// set may then begin; input stalls from the item marked last until then.
`default_nettype none
module roc_auc_trapezoid #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire roc_auc_pkg::in_item_t  in_item_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output roc_auc_pkg::out_item_t      out_item_o
);

  roc_auc_pkg::cmd_t    cmd;
  roc_auc_pkg::status_t status;

  // Sequencer.
  roc_auc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath and stores.
  roc_auc_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire
